>>> sv/bmre_pkg.sv
`default_nettype none
package bmre_pkg;

	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BOOT_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_ENABLE = 2'd1;

	localparam logic [3:0] MIN_REPORT_BYTES  = 4'd3;
	localparam logic [3:0] BOOT_REPORT_BYTES = 4'd4;

	localparam int unsigned NUM_SLOTS = 7;
	localparam int unsigned SLOT_W    = 3;

	localparam logic [SLOT_W-1:0] SLOT_X      = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_Y      = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_WHEEL  = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_LEFT   = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_RIGHT  = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_MIDDLE = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_SYNC   = 3'd6;

	typedef enum logic [1:0] {
		KIND_MOTION = 2'd0,
		KIND_BUTTON = 2'd1,
		KIND_SYNC   = 2'd2
	} kind_t;

	localparam logic [1:0] CODE_X      = 2'd0;
	localparam logic [1:0] CODE_Y      = 2'd1;
	localparam logic [1:0] CODE_WHEEL  = 2'd2;
	localparam logic [1:0] CODE_LEFT   = 2'd0;
	localparam logic [1:0] CODE_RIGHT  = 2'd1;
	localparam logic [1:0] CODE_MIDDLE = 2'd2;
	localparam logic [1:0] CODE_SYNC   = 2'd0;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = 1;
	localparam int unsigned QCNT_W      = 2;

	typedef struct packed {
		logic [NUM_SLOTS-1:0] slots;
		logic signed [7:0]    dx;
		logic signed [7:0]    dy;
		logic signed [7:0]    wh;
		logic [2:0]           btn;
	} entry_t;

endpackage
`default_nettype wire

>>> sv/bmre_if.sv
`default_nettype none
interface bmre_cfg_if;
	import bmre_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic                 data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface bmre_report_if;
	logic              valid;
	logic              ready;
	logic [3:0]        report_length;
	logic [7:0]        button_bits;
	logic signed [7:0] x_move;
	logic signed [7:0] y_move;
	logic signed [7:0] wheel_move;
	modport source (output valid, output report_length, output button_bits, output x_move,
		output y_move, output wheel_move, input ready);
	modport sink (input valid, input report_length, input button_bits, input x_move,
		input y_move, input wheel_move, output ready);
endinterface

interface bmre_event_if;
	logic              valid;
	logic              ready;
	logic [1:0]        event_kind;
	logic [1:0]        event_code;
	logic signed [7:0] event_value;
	logic              last_event;
	modport source (output valid, output event_kind, output event_code, output event_value,
		output last_event, input ready);
	modport sink (input valid, input event_kind, input event_code, input event_value,
		input last_event, output ready);
endinterface
`default_nettype wire

>>> sv/bmre_front.sv
`default_nettype none
module bmre_front
	import bmre_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	bmre_cfg_if.sink        cfg,
	bmre_report_if.sink     report,
	output logic            push_valid,
	input  wire logic       push_ready,
	output entry_t          push_data
);

	logic       boot_mode_q;
	logic       wheel_enable_q;
	logic [7:0] prev_buttons_q;

	logic              accept;
	logic              len_ok;
	logic signed [7:0] wh;
	logic [7:0]        pressed;
	logic [7:0]        released;
	logic [7:0]        toggled;
	logic              motion;
	logic              changed;

	assign cfg.ready    = 1'b1;
	assign report.ready = push_ready;
	assign accept       = report.valid && push_ready;

	always_comb begin
		len_ok = (report.report_length >= MIN_REPORT_BYTES) &&
			!(boot_mode_q && (report.report_length > BOOT_REPORT_BYTES));
		wh = (wheel_enable_q && (report.report_length >= BOOT_REPORT_BYTES)) ?
			report.wheel_move : 8'sd0;
		pressed  = report.button_bits & ~prev_buttons_q;
		released = prev_buttons_q & ~report.button_bits;
		toggled  = pressed | released;
		motion   = (report.x_move != 8'sd0) || (report.y_move != 8'sd0) || (wh != 8'sd0);
		changed  = (toggled != 8'd0);
	end

	always_comb begin
		push_data.slots              = '0;
		push_data.slots[SLOT_X]      = (report.x_move != 8'sd0);
		push_data.slots[SLOT_Y]      = (report.y_move != 8'sd0);
		push_data.slots[SLOT_WHEEL]  = (wh != 8'sd0);
		push_data.slots[SLOT_LEFT]   = toggled[0];
		push_data.slots[SLOT_RIGHT]  = toggled[1];
		push_data.slots[SLOT_MIDDLE] = toggled[2];
		push_data.slots[SLOT_SYNC]   = 1'b1;
		push_data.dx                 = report.x_move;
		push_data.dy                 = report.y_move;
		push_data.wh                 = wh;
		push_data.btn                = report.button_bits[2:0];
	end

	assign push_valid = report.valid && len_ok && (motion || changed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_mode_q    <= 1'b0;
			wheel_enable_q <= 1'b1;
			prev_buttons_q <= 8'd0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == CFG_BOOT_MODE) begin
					boot_mode_q <= cfg.data;
				end else if (cfg.index == CFG_WHEEL_ENABLE) begin
					wheel_enable_q <= cfg.data;
				end
			end
			if (accept && len_ok) begin
				prev_buttons_q <= report.button_bits;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/bmre_queue.sv
`default_nettype none
module bmre_queue
	import bmre_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push_valid,
	output logic        push_ready,
	input  wire entry_t push_data,
	output logic        pop_valid,
	input  wire logic   pop,
	output entry_t      pop_data
);

	entry_t              mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/bmre_back.sv
`default_nettype none
module bmre_back
	import bmre_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    pop_valid,
	output logic         pop,
	input  wire entry_t  pop_data,
	bmre_event_if.source evt
);

	entry_t               work_q;
	logic [NUM_SLOTS-1:0] rem_q;
	logic                 busy_q;
	logic                 out_valid_q;
	kind_t                kind_q;
	logic [1:0]           code_q;
	logic signed [7:0]    value_q;
	logic                 last_q;

	logic                 adv;
	logic                 emit;
	logic [SLOT_W-1:0]    sel;
	logic                 found;
	logic [NUM_SLOTS-1:0] rem_next;
	kind_t                kind_d;
	logic [1:0]           code_d;
	logic signed [7:0]    value_d;
	logic                 last_d;

	assign adv  = !out_valid_q || evt.ready;
	assign emit = adv && busy_q;

	always_comb begin
		sel   = SLOT_SYNC;
		found = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (!found && rem_q[i]) begin
				sel   = SLOT_W'(i);
				found = 1'b1;
			end
		end
		rem_next      = rem_q;
		rem_next[sel] = 1'b0;
	end

	assign pop = pop_valid && (!busy_q || (emit && (rem_next == '0)));

	always_comb begin
		kind_d  = KIND_SYNC;
		code_d  = CODE_SYNC;
		value_d = 8'sd0;
		last_d  = 1'b0;
		unique case (sel)
			SLOT_X: begin
				kind_d  = KIND_MOTION;
				code_d  = CODE_X;
				value_d = work_q.dx;
			end
			SLOT_Y: begin
				kind_d  = KIND_MOTION;
				code_d  = CODE_Y;
				value_d = work_q.dy;
			end
			SLOT_WHEEL: begin
				kind_d  = KIND_MOTION;
				code_d  = CODE_WHEEL;
				value_d = work_q.wh;
			end
			SLOT_LEFT: begin
				kind_d  = KIND_BUTTON;
				code_d  = CODE_LEFT;
				value_d = {7'd0, work_q.btn[0]};
			end
			SLOT_RIGHT: begin
				kind_d  = KIND_BUTTON;
				code_d  = CODE_RIGHT;
				value_d = {7'd0, work_q.btn[1]};
			end
			SLOT_MIDDLE: begin
				kind_d  = KIND_BUTTON;
				code_d  = CODE_MIDDLE;
				value_d = {7'd0, work_q.btn[2]};
			end
			default: begin
				kind_d  = KIND_SYNC;
				code_d  = CODE_SYNC;
				value_d = 8'sd0;
				last_d  = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				rem_q  <= pop_data.slots;
			end else if (emit) begin
				busy_q <= (rem_next != '0);
				rem_q  <= rem_next;
			end
			if (adv) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= pop_data;
		end
		if (emit) begin
			kind_q  <= kind_d;
			code_q  <= code_d;
			value_q <= value_d;
			last_q  <= last_d;
		end
	end

	assign evt.valid       = out_valid_q;
	assign evt.event_kind  = kind_q;
	assign evt.event_code  = code_q;
	assign evt.event_value = value_q;
	assign evt.last_event  = last_q;

endmodule
`default_nettype wire

>>> sv/boot_mouse_report_to_events.sv
`default_nettype none
// Boot mouse report decoder. Each accepted report yields a run of up to seven
// events (X, Y, wheel motion, left/right/middle edges, closing sync), one per
// cycle from a registered output while the event side is ready; the event
// serializer sets the sustained rate at one event per cycle. Reports are
// classified on arrival and wait in a two-entry queue, so the report side
// keeps accepting while the event side stalls until the queue is full behind
// the report being serialized; reports that yield no events never enter the
// queue, but they too wait while the queue is full. Configuration writes are
// taken every cycle.
module boot_mouse_report_to_events
	import bmre_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	bmre_cfg_if.sink     cfg,
	bmre_report_if.sink  report,
	bmre_event_if.source evt
);

	logic   push_valid;
	logic   push_ready;
	entry_t push_data;
	logic   pop_valid;
	logic   pop;
	entry_t pop_data;

	bmre_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.report     (report),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	bmre_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	bmre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data),
		.evt       (evt)
	);

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import bmre_pkg::*;

	localparam logic [3:0] REPORT_BYTES = 4'd8;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int DRAIN_CYCLES = 10;
	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 70;
	localparam logic [1:0] BUTTON_CODES [3] = '{CODE_LEFT, CODE_RIGHT, CODE_MIDDLE};

	typedef enum logic {ROW_REPORT, ROW_CONFIG} row_op_t;

	typedef struct packed {
		logic [3:0]        len;
		logic [7:0]        btn;
		logic signed [7:0] dx;
		logic signed [7:0] dy;
		logic signed [7:0] wh;
	} report_t;

	typedef struct packed {
		kind_t             kind;
		logic [1:0]        code;
		logic signed [7:0] value;
		logic              last;
	} mouse_event_t;

	typedef struct {
		row_op_t              op;
		report_t              rpt;
		logic [CFG_IDX_W-1:0] idx;
		logic                 data;
		int                   n_typed;
		mouse_event_t         first;
	} row_t;

	localparam mouse_event_t SYNC_EVENT = '{KIND_SYNC, CODE_SYNC, 8'sd0, 1'b1};

	logic clk = 1'b0;
	logic arst_n;

	bmre_cfg_if    cfg_bus ();
	bmre_report_if rpt_bus ();
	bmre_event_if  evt_bus ();

	boot_mouse_report_to_events u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.report (rpt_bus),
		.evt    (evt_bus)
	);

	logic         boot_mode_cfg = 1'b0;
	logic         wheel_en_cfg  = 1'b1;
	logic [7:0]   last_buttons  = 8'h00;
	mouse_event_t pending_events [$];
	row_t         dir_rows [$];
	int           mismatches    = 0;
	int           quiet_cycles  = 0;
	bit           src_idle      = 1'b1;
	bit           sink_idle     = 1'b1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void decode_report(input report_t r, output mouse_event_t run [$]);
		logic [3:0]        span;
		logic [7:0]        pressed;
		logic [7:0]        released;
		logic signed [7:0] wheel;
		run = {};
		span = (r.len > REPORT_BYTES) ? REPORT_BYTES : r.len;
		if (span < MIN_REPORT_BYTES)
			return;
		if (boot_mode_cfg && span > BOOT_REPORT_BYTES)
			return;
		wheel = (wheel_en_cfg && span >= BOOT_REPORT_BYTES) ? r.wh : 8'sd0;
		pressed = r.btn & ~last_buttons;
		released = last_buttons & ~r.btn;
		last_buttons = r.btn;
		if (r.dx == 0 && r.dy == 0 && wheel == 0 && pressed == 0 && released == 0)
			return;
		if (r.dx != 0)
			run.push_back('{KIND_MOTION, CODE_X, r.dx, 1'b0});
		if (r.dy != 0)
			run.push_back('{KIND_MOTION, CODE_Y, r.dy, 1'b0});
		if (wheel != 0)
			run.push_back('{KIND_MOTION, CODE_WHEEL, wheel, 1'b0});
		for (int b = 0; b < 3; b++) begin
			if (pressed[b])
				run.push_back('{KIND_BUTTON, BUTTON_CODES[b], 8'sd1, 1'b0});
			if (released[b])
				run.push_back('{KIND_BUTTON, BUTTON_CODES[b], 8'sd0, 1'b0});
		end
		run.push_back(SYNC_EVENT);
	endfunction

	function automatic void add_row(input logic [3:0] len, input logic [7:0] btn,
		input logic signed [7:0] dx, input logic signed [7:0] dy,
		input logic signed [7:0] wh, input int n = -1, input kind_t k = KIND_SYNC,
		input logic [1:0] c = CODE_SYNC, input logic signed [7:0] v = 8'sd0);
		row_t row;
		row.op = ROW_REPORT;
		row.rpt = '{len, btn, dx, dy, wh};
		row.idx = CFG_BOOT_MODE;
		row.data = 1'b0;
		row.n_typed = n;
		row.first = '{k, c, v, 1'b0};
		dir_rows.push_back(row);
	endfunction

	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic data);
		row_t row;
		row.op = ROW_CONFIG;
		row.rpt = '0;
		row.idx = idx;
		row.data = data;
		row.n_typed = -1;
		row.first = SYNC_EVENT;
		dir_rows.push_back(row);
	endfunction

	function automatic report_t random_report();
		report_t r;
		int      pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			r.len = 4'($urandom_range(3, 4));
		else if (pick < 85)
			r.len = 4'($urandom_range(5, 8));
		else
			r.len = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < 45)
			r.btn = last_buttons ^ (8'h01 << $urandom_range(0, 2));
		else if (pick < 75)
			r.btn = last_buttons;
		else
			r.btn = 8'($urandom_range(0, 255));
		r.dx = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255)) : 8'sd0;
		r.dy = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255)) : 8'sd0;
		r.wh = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255)) : 8'sd0;
		return r;
	endfunction

	task automatic send_report(input report_t r, input int n_typed, input mouse_event_t first);
		int           gap;
		mouse_event_t run [$];
		gap = src_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			rpt_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rpt_bus.valid         <= 1'b1;
		rpt_bus.report_length <= r.len;
		rpt_bus.button_bits   <= r.btn;
		rpt_bus.x_move        <= r.dx;
		rpt_bus.y_move        <= r.dy;
		rpt_bus.wheel_move    <= r.wh;
		do @(posedge clk); while (rpt_bus.ready !== 1'b1);
		decode_report(r, run);
		if (n_typed >= 0) begin
			run = {};
			if (n_typed == 2)
				run.push_back(first);
			if (n_typed >= 1)
				run.push_back(SYNC_EVENT);
		end
		foreach (run[i])
			pending_events.push_back(run[i]);
	endtask

	task automatic wait_drain();
		rpt_bus.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		if (idx == CFG_BOOT_MODE)
			boot_mode_cfg = data;
		else if (idx == CFG_WHEEL_ENABLE)
			wheel_en_cfg = data;
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic compare_event(input mouse_event_t got);
		mouse_event_t want;
		if (pending_events.size() == 0) begin
			$error("unexpected event: kind %0d code %0d value %0d last %0d",
				got.kind, got.code, got.value, got.last);
			mismatches++;
			return;
		end
		want = pending_events.pop_front();
		if (got.kind !== want.kind) begin
			$error("event_kind: expected %0d, actual %0d", want.kind, got.kind);
			mismatches++;
		end
		if (got.code !== want.code) begin
			$error("event_code: expected %0d, actual %0d", want.code, got.code);
			mismatches++;
		end
		if (got.value !== want.value) begin
			$error("event_value: expected %0d, actual %0d", want.value, got.value);
			mismatches++;
		end
		if (got.last !== want.last) begin
			$error("last_event: expected %0d, actual %0d", want.last, got.last);
			mismatches++;
		end
	endtask

	initial begin
		int stall;
		evt_bus.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = sink_idle ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				evt_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			evt_bus.ready <= 1'b1;
			do @(posedge clk); while (evt_bus.valid !== 1'b1);
			compare_event('{kind_t'(evt_bus.event_kind), evt_bus.event_code,
				evt_bus.event_value, evt_bus.last_event});
		end
	end

	always @(posedge clk) begin
		if ((rpt_bus.valid && rpt_bus.ready) || (evt_bus.valid && evt_bus.ready)
			|| (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n                <= 1'b0;
		cfg_bus.valid         <= 1'b0;
		cfg_bus.index         <= CFG_BOOT_MODE;
		cfg_bus.data          <= 1'b0;
		rpt_bus.valid         <= 1'b0;
		rpt_bus.report_length <= 4'd0;
		rpt_bus.button_bits   <= 8'h00;
		rpt_bus.x_move        <= 8'sd0;
		rpt_bus.y_move        <= 8'sd0;
		rpt_bus.wheel_move    <= 8'sd0;

		add_row(4'd0, 8'hFF, 8'sd127, 8'sd127, 8'sd127, 0);
		add_row(4'd2, 8'h07, -8'sd1, -8'sd1, -8'sd1, 0);
		add_row(4'd3, 8'h00, 8'sd0, 8'sd0, 8'sd5, 0);
		add_row(4'd3, 8'h00, 8'sd127, 8'sd0, 8'sd0, 2, KIND_MOTION, CODE_X, 8'sd127);
		add_row(4'd3, 8'h00, 8'sd0, -8'sd128, 8'sd0, 2, KIND_MOTION, CODE_Y, -8'sd128);
		add_row(4'd4, 8'h00, 8'sd0, 8'sd0, -8'sd128, 2, KIND_MOTION, CODE_WHEEL, -8'sd128);
		add_row(4'd3, 8'h08, 8'sd0, 8'sd0, 8'sd0, 1);
		add_row(4'd3, 8'hF8, 8'sd0, 8'sd0, 8'sd0, 1);
		add_row(4'd3, 8'h01, 8'sd0, 8'sd0, 8'sd0, 2, KIND_BUTTON, CODE_LEFT, 8'sd1);
		add_row(4'd3, 8'h00, 8'sd0, 8'sd0, 8'sd0, 2, KIND_BUTTON, CODE_LEFT, 8'sd0);
		add_row(4'd8, 8'h07, 8'sd1, -8'sd1, 8'sd1);
		add_row(4'd15, 8'h00, -8'sd128, 8'sd127, 8'sd127);
		add_row(4'd9, 8'h02, 8'sd0, 8'sd0, 8'sd0);
		add_row(4'd4, 8'h02, 8'sd0, 8'sd0, 8'sd0, 0);
		add_cfg(CFG_BOOT_MODE, 1'b1);
		add_row(4'd5, 8'h05, 8'sd3, 8'sd3, 8'sd3, 0);
		add_row(4'd8, 8'h00, -8'sd9, 8'sd0, 8'sd0, 0);
		add_row(4'd4, 8'h04, 8'sd10, 8'sd20, -8'sd30);
		add_cfg(CFG_WHEEL_ENABLE, 1'b0);
		add_row(4'd4, 8'h04, 8'sd0, 8'sd0, 8'sd99, 0);
		add_row(4'd4, 8'h00, 8'sd0, 8'sd0, 8'sd99, 2, KIND_BUTTON, CODE_MIDDLE, 8'sd0);
		add_cfg(CFG_SPARE_B, 1'b1);
		add_cfg(CFG_SPARE_A, 1'b1);
		add_row(4'd4, 8'h00, 8'sd0, 8'sd0, 8'sd7, 0);
		add_cfg(CFG_BOOT_MODE, 1'b0);
		add_cfg(CFG_WHEEL_ENABLE, 1'b1);
		add_row(4'd6, 8'h00, 8'sd0, 8'sd0, 8'sd7);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].op == ROW_CONFIG) begin
				wait_drain();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_report(dir_rows[i].rpt, dir_rows[i].n_typed, dir_rows[i].first);
			end
		end

		for (int phase = 0; phase < 4; phase++) begin
			wait_drain();
			write_reg(CFG_BOOT_MODE, phase == 1 || phase == 2);
			write_reg(CFG_WHEEL_ENABLE, phase < 2);
			write_reg((phase % 2 == 0) ? CFG_SPARE_A : CFG_SPARE_B, 1'($urandom_range(0, 1)));
			src_idle = (phase == 0 || phase == 2);
			sink_idle = (phase == 0 || phase == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase == 0 && i == PHASE_ITEMS / 2)
					wait_drain();
				send_report(random_report(), -1, SYNC_EVENT);
			end
		end

		wait_drain();
		if (mismatches == 0 && pending_events.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
